// File: rtl/spr_pkg.sv
// Shared types and constants of the sequence pattern replace block.
// No dependencies; compiled before every other file of the block.
package spr_pkg;

  localparam int WORD_W    = 32;
  localparam int KIND_W    = 2;
  localparam int SLOT_W    = 3;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 8;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [KIND_W-1:0]        kind_t;

  // Input word kinds
  localparam kind_t KIND_LOAD_PAT = 2'd0;
  localparam kind_t KIND_LOAD_REP = 2'd1;
  localparam kind_t KIND_SEQ      = 2'd2;
  localparam kind_t KIND_END      = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 8'd1;

  // Control of the held/pattern cell row
  typedef struct packed {
    logic pat_we;   // write one pattern cell
    logic append;   // load the next free held cell
    logic shift;    // release the oldest held word, move the rest down
  } spr_chain_ctrl_t;

endpackage

// File: rtl/spr_cell.sv
// One match cell: a pattern word, a held word and their comparison.
// Depends on spr_pkg.
module spr_cell import spr_pkg::*; (
  input  logic  clk,
  input  logic  pat_we,
  input  word_t pat_data,
  input  logic  held_load,
  input  word_t held_in,
  input  logic  held_shift,
  input  word_t shift_in,
  output word_t held_out,
  output logic  match
);

  word_t pat_r;
  word_t held_r;

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_r <= pat_data;
    end
    if (held_load) begin
      held_r <= held_in;
    end else if (held_shift) begin
      held_r <= shift_in;
    end
  end

  assign held_out = held_r;
  assign match    = (held_r == pat_r);

endmodule

// File: rtl/spr_chain.sv
// Row of match cells holding the pattern and the words held as a possible match.
// Depends on spr_pkg and spr_cell.
module spr_chain import spr_pkg::*; #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                                   clk,
  input  spr_chain_ctrl_t                        ctrl,
  input  logic [(MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1)-1:0] pat_idx,
  input  word_t                                  pat_data,
  input  word_t                                  app_data,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]       count,
  output word_t                                  head,
  output logic                                   prefix_match
);

  localparam int PIDX_W = MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W  = $clog2(MAX_PATTERN + 1);

  word_t                  held_w [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] match_w;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    word_t shift_in_w;
    if (k == MAX_PATTERN - 1) begin : g_tail
      assign shift_in_w = held_w[k];
    end else begin : g_mid
      assign shift_in_w = held_w[k+1];
    end

    spr_cell u_cell (
      .clk        (clk),
      .pat_we     (ctrl.pat_we && (pat_idx == PIDX_W'(k))),
      .pat_data   (pat_data),
      .held_load  (ctrl.append && (count == CNT_W'(k))),
      .held_in    (app_data),
      .held_shift (ctrl.shift),
      .shift_in   (shift_in_w),
      .held_out   (held_w[k]),
      .match      (match_w[k])
    );
  end

  // Held words below the count must equal the leading pattern words
  always_comb begin
    prefix_match = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((CNT_W'(k) < count) && !match_w[k]) begin
        prefix_match = 1'b0;
      end
    end
  end

  assign head = held_w[0];

endmodule

// File: rtl/spr_ring.sv
// Ring of replacement cells; rotating by the replacement length presents each
// word at the head in turn and leaves the ring in its home position.
// Depends on spr_pkg.
module spr_ring import spr_pkg::*; #(
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [(MAX_REPLACEMENT > 1 ? $clog2(MAX_REPLACEMENT) : 1)-1:0] wr_idx,
  input  word_t                                      wr_data,
  input  logic                                       rot,
  input  logic [$clog2(MAX_REPLACEMENT+1)-1:0]       len,
  output word_t                                      head
);

  localparam int RIDX_W = MAX_REPLACEMENT > 1 ? $clog2(MAX_REPLACEMENT) : 1;
  localparam int RCNT_W = $clog2(MAX_REPLACEMENT + 1);

  word_t cell_r [MAX_REPLACEMENT];

  for (genvar k = 0; k < MAX_REPLACEMENT; k++) begin : g_cell
    word_t next_w;
    if (k == MAX_REPLACEMENT - 1) begin : g_tail
      assign next_w = (len == RCNT_W'(k + 1)) ? cell_r[0] : cell_r[k];
    end else begin : g_mid
      // wrap at the last word in use, hold the words beyond it
      assign next_w = (len == RCNT_W'(k + 1)) ? cell_r[0] :
                      (RCNT_W'(k + 1) < len)  ? cell_r[k+1] : cell_r[k];
    end

    always_ff @(posedge clk) begin
      if (wr_en && (wr_idx == RIDX_W'(k))) begin
        cell_r[k] <= wr_data;
      end else if (rot) begin
        cell_r[k] <= next_w;
      end
    end
  end

  assign head = cell_r[0];

endmodule

// File: rtl/sequence_pattern_replace.sv
// Stream find-and-replace over signed 32-bit words.
// Depends on spr_pkg, spr_chain (with spr_cell) and spr_ring.
//
// Usage: input words arrive on the in_ channel; in_tuser carries the kind
// (load pattern word, load replacement word, sequence word, end of sequence),
// in_tdata the slot and the word. Lengths of pattern and replacement are set
// through the cfg_ port; the user must write them only while the block is
// idle, the block itself does not enforce it. Rewritten words leave on the
// out_ channel, with out_tlast on the final word caused by one input word.
// Input words are taken one at a time: in_tready is high only while idle.
// Each release shifts the whole held-word cell row by one place and each
// replacement word rotates the replacement ring by one place, so one result
// word leaves per cycle while out_tready does not stall the output path.
// Each result word passes a pending register and then the output register
// before it appears on out_.
// Reset clears held count, lengths and control; stored pattern and
// replacement words keep their contents until written.
// A stall on out_tready freezes the sequencer at its next emission; in_tready
// stays low until all results of the current word are in the output path.
module sequence_pattern_replace import spr_pkg::*; #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // [2:0] slot, [34:3] word, [39:35] zero
  input  logic [KIND_W-1:0]    in_tuser,   // [1:0] kind
  // result words
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [WORD_W-1:0]    out_tdata,  // [31:0] out_word
  output logic                 out_tlast,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  localparam int PIDX_W = MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
  localparam int RIDX_W = MAX_REPLACEMENT > 1 ? $clog2(MAX_REPLACEMENT) : 1;
  localparam int RCNT_W = $clog2(MAX_REPLACEMENT + 1);
  localparam int PW     = CNT_W > LEN_W ? CNT_W : LEN_W;
  localparam int RW     = RCNT_W > LEN_W ? RCNT_W : LEN_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FLUSH, ST_SCAN, ST_REPL, ST_TAIL, ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    MODE_SCAN, MODE_PASS, MODE_END
  } mode_t;

  // registers
  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  word_t              word_r, word_nxt;
  logic               need_rep_r, need_rep_nxt;
  logic               prefix_done_r, prefix_done_nxt;
  logic               appended_r, appended_nxt;
  logic [CNT_W-1:0]   held_count_r, held_count_nxt;
  logic [RCNT_W-1:0]  rep_idx_r, rep_idx_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  word_t              pend_word_r, pend_word_nxt;
  logic               out_valid_r, out_valid_nxt;
  word_t              out_word_r, out_word_nxt;
  logic               out_last_r, out_last_nxt;
  logic [LEN_W-1:0]   pattern_length_r;
  logic [LEN_W-1:0]   replacement_length_r;

  // decoded input
  kind_t              in_kind;
  logic [SLOT_W-1:0]  in_slot;
  word_t              in_word;
  logic               in_accept;

  // saturated lengths
  logic [PW-1:0]      plen_ext;
  logic [RW-1:0]      rlen_ext;
  logic [CNT_W-1:0]   p_sat;
  logic [RCNT_W-1:0]  t_sat;

  // datapath control
  spr_chain_ctrl_t    chain_ctrl;
  logic               rep_we;
  logic               rep_rot;
  word_t              held_head;
  word_t              rep_head;
  logic               prefix_match;
  logic               prefix_ok;
  logic               out_free;
  logic               emit_ok;
  logic               emit;
  word_t              emit_word;
  logic               fin_push;

  assign in_kind   = in_tuser;
  assign in_slot   = in_tdata[SLOT_W-1:0];
  assign in_word   = word_t'(in_tdata[SLOT_W+WORD_W-1:SLOT_W]);
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign plen_ext = PW'(pattern_length_r);
  assign rlen_ext = RW'(replacement_length_r);
  assign p_sat = (plen_ext > PW'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : CNT_W'(plen_ext);
  assign t_sat = (rlen_ext > RW'(MAX_REPLACEMENT)) ? RCNT_W'(MAX_REPLACEMENT)
                                                     : RCNT_W'(rlen_ext);

  assign prefix_ok = prefix_match && (held_count_r <= p_sat);
  assign out_free  = !out_valid_r || out_tready;
  assign emit_ok   = !pend_valid_r || out_free;

  spr_chain #(.MAX_PATTERN(MAX_PATTERN)) u_chain (
    .clk          (clk),
    .ctrl         (chain_ctrl),
    .pat_idx      (PIDX_W'(in_slot)),
    .pat_data     (in_word),
    .app_data     (word_r),
    .count        (held_count_r),
    .head         (held_head),
    .prefix_match (prefix_match)
  );

  spr_ring #(.MAX_REPLACEMENT(MAX_REPLACEMENT)) u_ring (
    .clk     (clk),
    .wr_en   (rep_we),
    .wr_idx  (RIDX_W'(in_slot)),
    .wr_data (in_word),
    .rot     (rep_rot),
    .len     (t_sat),
    .head    (rep_head)
  );

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    word_nxt        = word_r;
    need_rep_nxt    = need_rep_r;
    prefix_done_nxt = prefix_done_r;
    appended_nxt    = appended_r;
    held_count_nxt  = held_count_r;
    rep_idx_nxt     = rep_idx_r;
    chain_ctrl      = '0;
    rep_we          = 1'b0;
    rep_rot         = 1'b0;
    emit            = 1'b0;
    emit_word       = word_r;
    fin_push        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_kind)
            KIND_LOAD_PAT: begin
              chain_ctrl.pat_we = (32'(in_slot) < 32'(MAX_PATTERN));
            end
            KIND_LOAD_REP: begin
              rep_we = (32'(in_slot) < 32'(MAX_REPLACEMENT));
            end
            KIND_SEQ: begin
              word_nxt        = in_word;
              need_rep_nxt    = (p_sat == '0) && (t_sat != '0) && !prefix_done_r;
              prefix_done_nxt = 1'b1;
              if ((p_sat == '0) || (t_sat == '0)) begin
                mode_nxt  = MODE_PASS;
                state_nxt = ST_FLUSH;
              end else begin
                mode_nxt     = MODE_SCAN;
                appended_nxt = 1'b0;
                state_nxt    = ST_SCAN;
              end
            end
            KIND_END: begin
              need_rep_nxt    = (p_sat == '0) && (t_sat != '0) && !prefix_done_r;
              prefix_done_nxt = 1'b0;
              mode_nxt        = MODE_END;
              state_nxt       = ST_FLUSH;
            end
            default: ;
          endcase
        end
      end

      ST_FLUSH: begin
        priority if (held_count_r != '0) begin
          if (emit_ok) begin
            emit             = 1'b1;
            emit_word        = held_head;
            chain_ctrl.shift = 1'b1;
            held_count_nxt   = held_count_r - 1'b1;
          end
        end else if (need_rep_r) begin
          rep_idx_nxt = '0;
          state_nxt   = ST_REPL;
        end else if (mode_r == MODE_PASS) begin
          state_nxt = ST_TAIL;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_SCAN: begin
        priority if (!prefix_ok) begin
          // release the oldest held word and retry from the next one
          if (emit_ok) begin
            emit             = 1'b1;
            emit_word        = held_head;
            chain_ctrl.shift = 1'b1;
            held_count_nxt   = held_count_r - 1'b1;
          end
        end else if (!appended_r) begin
          chain_ctrl.append = 1'b1;
          held_count_nxt    = held_count_r + 1'b1;
          appended_nxt      = 1'b1;
        end else if (held_count_r == p_sat) begin
          held_count_nxt = '0;
          rep_idx_nxt    = '0;
          state_nxt      = ST_REPL;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_REPL: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_word = rep_head;
          rep_rot   = 1'b1;
          if (rep_idx_r == RCNT_W'(t_sat - 1'b1)) begin
            rep_idx_nxt = '0;
            state_nxt   = (mode_r == MODE_PASS) ? ST_TAIL : ST_FIN;
          end else begin
            rep_idx_nxt = rep_idx_r + 1'b1;
          end
        end
      end

      ST_TAIL: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_word = word_r;
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        // the pending word is the last one of this input word
        if (emit_ok) begin
          fin_push  = pend_valid_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // pending word and output register
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_word_nxt  = pend_word_r;
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if ((emit && pend_valid_r) || fin_push) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = pend_word_r;
      out_last_nxt  = fin_push;
    end
    if (emit) begin
      pend_valid_nxt = 1'b1;
      pend_word_nxt  = emit_word;
    end else if (fin_push) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= ST_IDLE;
      mode_r               <= MODE_SCAN;
      need_rep_r           <= 1'b0;
      prefix_done_r        <= 1'b0;
      appended_r           <= 1'b0;
      held_count_r         <= '0;
      rep_idx_r            <= '0;
      pend_valid_r         <= 1'b0;
      out_valid_r          <= 1'b0;
      out_last_r           <= 1'b0;
      pattern_length_r     <= '0;
      replacement_length_r <= '0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      need_rep_r    <= need_rep_nxt;
      prefix_done_r <= prefix_done_nxt;
      appended_r    <= appended_nxt;
      held_count_r  <= held_count_nxt;
      rep_idx_r     <= rep_idx_nxt;
      pend_valid_r  <= pend_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      out_last_r    <= out_last_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PATTERN_LENGTH) begin
          pattern_length_r <= cfg_data;
        end else if (cfg_index == REG_REPLACEMENT_LENGTH) begin
          replacement_length_r <= cfg_data;
        end
      end
    end
    word_r      <= word_nxt;
    pend_word_r <= pend_word_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;

  // Nothing stays pending once the block is ready for the next word
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("pending word left behind at idle");

  // Between items fewer than MAX_PATTERN words are held
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (32'(held_count_r) < MAX_PATTERN))
    else $error("held count too large at idle");

  // Replacement output only with a non-empty replacement, index in range
  a_repl_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPL) |-> ((t_sat != '0) && (rep_idx_r < t_sat)))
    else $error("replacement index out of range");

  // A match is only declared after the new word has been appended
  a_match_after_append: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && (state_nxt == ST_REPL)) |-> appended_r)
    else $error("replacement started without append");

endmodule

// File: sim/tb_sequence_pattern_replace.sv
// Self-checking testbench of sequence_pattern_replace: directed and random word streams.
// An in-bench predictor of the find-and-replace rewrite checks every out_ word and tlast.
// Depends on spr_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_sequence_pattern_replace;
  import spr_pkg::*;

  localparam int STORE_DEPTH   = 8;
  localparam int ITEM_TARGET   = 410;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

  typedef struct {
    word_t w;
    logic  last;
  } rewritten_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [39:0]          in_tdata = '0;   // [2:0] slot, [34:3] word, [39:35] zero
  logic [KIND_W-1:0]    in_tuser = '0;   // [1:0] kind
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [WORD_W-1:0]    out_tdata;       // [31:0] out_word
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;

  // predictor state
  word_t      pat_mem [STORE_DEPTH];
  word_t      rep_mem [STORE_DEPTH];
  word_t      held_q [$];
  word_t      step_words [$];
  logic       seq_started = 1'b0;
  logic [3:0] pat_len_reg = '0;
  logic [3:0] rep_len_reg = '0;

  rewritten_t rewritten_q [$];
  rewritten_t exp_word;
  int         errors = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  int         stalled_cycles = 0;
  int         rx_mode = 0;
  int         rx_left = 0;
  int         rx_tick = 0;

  sequence_pattern_replace dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_len(logic [3:0] v);
    return (v > STORE_DEPTH) ? STORE_DEPTH : int'(v);
  endfunction

  function automatic bit held_is_pattern_prefix(int p);
    if (held_q.size() > p) return 1'b0;
    foreach (held_q[i])
      if (held_q[i] !== pat_mem[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void release_held();
    while (held_q.size() > 0) step_words.push_back(held_q.pop_front());
  endfunction

  function automatic void emit_replacement(int t);
    for (int k = 0; k < t; k++) step_words.push_back(rep_mem[k]);
  endfunction

  function automatic void rewrite_word(kind_t kind, logic [SLOT_W-1:0] slot, word_t w);
    int p;
    int t;
    rewritten_t r;
    p = eff_len(pat_len_reg);
    t = eff_len(rep_len_reg);
    step_words.delete();
    case (kind)
      KIND_LOAD_PAT: pat_mem[slot] = w;
      KIND_LOAD_REP: rep_mem[slot] = w;
      KIND_SEQ: begin
        if (p == 0 || t == 0) begin
          release_held();
          if (p == 0 && t != 0 && !seq_started) emit_replacement(t);
          step_words.push_back(w);
        end else begin
          // release held words that no longer lead into the pattern
          while (held_q.size() > 0 && !held_is_pattern_prefix(p))
            step_words.push_back(held_q.pop_front());
          held_q.push_back(w);
          while (!held_is_pattern_prefix(p)) step_words.push_back(held_q.pop_front());
          if (held_q.size() == p) begin
            emit_replacement(t);
            held_q.delete();
          end
        end
        seq_started = 1'b1;
      end
      default: begin
        release_held();
        if (p == 0 && t != 0 && !seq_started) emit_replacement(t);
        seq_started = 1'b0;
      end
    endcase
    foreach (step_words[i]) begin
      r.w = step_words[i];
      r.last = (i == step_words.size() - 1);
      rewritten_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_word(kind_t kind, logic [SLOT_W-1:0] slot, word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'b0, w, slot};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
    rewrite_word(kind, slot, w);
  endtask

  // hold the sender until every expected word has left, then let the block settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PATTERN_LENGTH) pat_len_reg = val;
    else if (idx == REG_REPLACEMENT_LENGTH) rep_len_reg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_lengths(logic [3:0] p, logic [3:0] r);
    wait_drained();
    write_reg(REG_PATTERN_LENGTH, p);
    write_reg(REG_REPLACEMENT_LENGTH, r);
  endtask

  function automatic word_t edge_word(int i);
    case (i % 8)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4: return 32'h5555_5555;
      5: return 32'hAAAA_AAAA;
      6: return 32'h0000_0001;
      default: return 32'hFFFF_FFFE;
    endcase
  endfunction

  function automatic logic [3:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'd8;
      2: return 4'($urandom_range(9, 15));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (rewritten_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
      end else begin
        exp_word = rewritten_q.pop_front();
        if (out_tdata !== exp_word.w) begin
          errors++;
          $display("%0t: out_word mismatch: expected %h, actual %h",
                   $time, exp_word.w, out_tdata);
        end
        if (out_tlast !== exp_word.last) begin
          errors++;
          $display("%0t: tlast mismatch: expected %b, actual %b",
                   $time, exp_word.last, out_tlast);
        end
      end
    end
    // receiver stall pattern: open, random, or one beat in five
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(8, 60);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= (rx_tick % 5 == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
  end

  initial begin
    while (stalled_cycles < STALL_LIMIT) @(posedge clk);
    $display("sequence_pattern_replace regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // lengths are zero after reset: words pass straight through
  task automatic test_pass_through();
    write_reg(REG_UNUSED, 4'hF);
    send_word(KIND_SEQ, 3'd7, edge_word(0));
    send_word(KIND_SEQ, 3'd0, edge_word(1));
    send_word(KIND_END, 3'd5, edge_word(2));
  endtask

  task automatic test_store_loads();
    for (int k = 0; k < STORE_DEPTH; k++) send_word(KIND_LOAD_PAT, 3'(k), edge_word(k));
    for (int k = 0; k < STORE_DEPTH; k++) send_word(KIND_LOAD_REP, 3'(k), edge_word(k + 3));
  endtask

  // failed partial match releases one word and restarts; end flushes the rest
  task automatic test_match_restart();
    set_lengths(4'd2, 4'd3);
    send_word(KIND_SEQ, 3'd0, edge_word(0));
    send_word(KIND_SEQ, 3'd1, edge_word(0));
    send_word(KIND_SEQ, 3'd2, edge_word(1));
    send_word(KIND_SEQ, 3'd3, edge_word(0));
    send_word(KIND_END, 3'd4, edge_word(5));
  endtask

  // held words stop being a prefix once the pattern is shortened
  task automatic test_shortened_pattern();
    set_lengths(4'd3, 4'd3);
    send_word(KIND_SEQ, 3'd0, edge_word(0));
    send_word(KIND_SEQ, 3'd0, edge_word(1));
    set_lengths(4'd1, 4'd3);
    send_word(KIND_SEQ, 3'd0, edge_word(0));
    send_word(KIND_END, 3'd0, edge_word(0));
  endtask

  task automatic test_rewrite_off_while_held();
    set_lengths(4'd2, 4'd2);
    send_word(KIND_SEQ, 3'd6, edge_word(0));
    set_lengths(4'd2, 4'd0);
    send_word(KIND_SEQ, 3'd6, edge_word(2));
  endtask

  // empty pattern: replacement leads each sequence, also an empty one
  task automatic test_empty_pattern();
    set_lengths(4'd0, 4'd15);
    send_word(KIND_SEQ, 3'd1, edge_word(3));
    send_word(KIND_SEQ, 3'd2, edge_word(4));
    send_word(KIND_END, 3'd3, edge_word(5));
    send_word(KIND_END, 3'd4, edge_word(6));
  endtask

  task automatic test_random_rewrite();
    int    phase;
    int    pick;
    int    plen;
    int    cut;
    int    stop;
    word_t alphabet [4];
    logic [3:0] p_cfg;
    logic [3:0] r_cfg;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: begin p_cfg = 4'd8;  r_cfg = 4'd8;  end
        1: begin p_cfg = 4'd15; r_cfg = 4'd15; end
        default: begin p_cfg = pick_length(); r_cfg = pick_length(); end
      endcase
      foreach (alphabet[k]) alphabet[k] = $urandom;
      // small alphabet so that stream words often hit the pattern
      for (int k = 0; k < STORE_DEPTH; k++)
        send_word(KIND_LOAD_PAT, 3'(k), alphabet[$urandom_range(0, 3)]);
      repeat ($urandom_range(0, 3))
        send_word(KIND_LOAD_REP, 3'($urandom_range(0, 7)), $urandom);
      set_lengths(p_cfg, r_cfg);
      plen = eff_len(p_cfg);
      stop = items_sent + 35;
      while (items_sent < stop && items_sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 45 && plen > 0) begin
          for (int k = 0; k < plen; k++)
            send_word(KIND_SEQ, 3'($urandom_range(0, 7)), pat_mem[k]);
        end else if (pick < 60 && plen > 1) begin
          cut = $urandom_range(1, plen - 1);
          for (int k = 0; k < cut; k++)
            send_word(KIND_SEQ, 3'($urandom_range(0, 7)), pat_mem[k]);
          send_word(KIND_SEQ, 3'($urandom_range(0, 7)), alphabet[$urandom_range(0, 3)]);
        end else if (pick < 80) begin
          send_word(KIND_SEQ, 3'($urandom_range(0, 7)), alphabet[$urandom_range(0, 3)]);
        end else if (pick < 90) begin
          send_word(KIND_SEQ, 3'($urandom_range(0, 7)), $urandom);
        end else if (pick < 96) begin
          send_word(KIND_END, 3'($urandom_range(0, 7)), $urandom);
        end else if (pick < 98) begin
          send_word(($urandom_range(0, 1) == 0) ? KIND_LOAD_PAT : KIND_LOAD_REP,
                    3'($urandom_range(0, 7)), alphabet[$urandom_range(0, 3)]);
        end else begin
          wait_drained();
        end
      end
      phase++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pass_through();
    test_store_loads();
    test_match_restart();
    test_shortened_pattern();
    test_rewrite_off_while_held();
    test_empty_pattern();
    test_random_rewrite();
    wait_drained();
    if (errors == 0 && rewritten_q.size() == 0)
      $display("sequence_pattern_replace regression: pass");
    else
      $display("sequence_pattern_replace regression: fail");
    $finish;
  end

endmodule
